/* hw/rtl/ccc_pkg.sv */
package ccc_pkg;

	// request codes carried in req_type
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_LOAD = 1'b1
	} ccc_req_type_t;

	localparam logic [15:0] DEFAULT_YEAR = 16'd2000;
	localparam logic [15:0] LAST_YEAR    = 16'd65535;
	localparam logic [15:0] FIRST_YEAR   = 16'd1;
	localparam logic [3:0]  MONTH_LAST   = 4'd12;
	localparam logic [4:0]  HOUR_LAST    = 5'd23;
	localparam logic [4:0]  HOURS_DAY    = 5'd24;
	localparam logic [4:0]  HOUR_NOON    = 5'd12;
	localparam logic [5:0]  MIN_LAST     = 6'd59;
	localparam logic [5:0]  SEC_LAST     = 6'd59;
	localparam logic [5:0]  UNITS_60     = 6'd60;

	// gregorian cycle length and a scaled reciprocal of 25, since 400 = 16 * 25:
	// floor(y / 400) = ((y >> 4) * RECIP) >> SHIFT, exact for every 16-bit year
	localparam logic [15:0] YEAR_SPAN        = 16'd400;
	localparam logic [8:0]  SPAN_LAST        = 9'd399;
	localparam logic [8:0]  MOD_OF_FIRST     = 9'd1;
	localparam logic [8:0]  MOD_OF_DEFAULT   = 9'd0;
	localparam logic [15:0] YEAR_RECIP       = 16'd5243;
	localparam int          YEAR_RECIP_SHIFT = 17;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [8:0]  year_mod400;
	} ccc_state_t;

	// request after the first stage: month, year and time already fixed up
	typedef struct packed {
		ccc_req_type_t req_type;
		logic [3:0]    month;
		logic [4:0]    day;
		logic [15:0]   year;
		logic [7:0]    year_div400;
		logic [4:0]    hour;
		logic [5:0]    minute;
		logic [5:0]    second;
	} ccc_load_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [3:0]  hour_twelve;
		logic        is_pm;
	} ccc_result_t;

	// leap test from the year modulo 400
	function automatic logic is_leap(input logic [8:0] ymod);
		logic div100;
		div100 = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
		return (ymod[1:0] == 2'b00) && !div100;
	endfunction

	// days in a month; codes outside 1..12 count as january
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] days;
		unique case (month)
			4'd2:                      days = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
			default:                   days = 5'd31;
		endcase
		return days;
	endfunction

endpackage

/* hw/rtl/ccc_req_if.sv */
interface ccc_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  set_month;
	logic [4:0]  set_day;
	logic [15:0] set_year;
	logic [4:0]  set_hour;
	logic [5:0]  set_minute;
	logic [5:0]  set_second;

	modport source (
		output valid, req_type, set_month, set_day, set_year, set_hour, set_minute, set_second,
		input  ready
	);
	modport sink (
		input  valid, req_type, set_month, set_day, set_year, set_hour, set_minute, set_second,
		output ready
	);
endinterface

/* hw/rtl/ccc_rsp_if.sv */
interface ccc_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [4:0]  cur_hour;
	logic [5:0]  cur_minute;
	logic [5:0]  cur_second;
	logic [3:0]  hour_twelve;
	logic        is_pm;

	modport source (
		output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
			hour_twelve, is_pm,
		input  ready
	);
	modport sink (
		input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
			hour_twelve, is_pm,
		output ready
	);
endinterface

/* hw/rtl/calendar_clock_counter_unit.sv */
// channel | dir | beat contents
// --------+-----+--------------------------------------------------------------
// req     | in  | req_type, set_month, set_day, set_year, set_hour, set_minute, set_second
// rsp     | out | cur_year .. cur_second, hour_twelve, is_pm (one beat per req beat)
//
// one req beat per cycle sustained while rsp.ready keeps the output register draining;
// a request is registered in the input stage, then its result beat in the output register
// the pipeline is the input register and the output register; the state update in
// ccc_advance (tick carry / load check) sits combinationally between them
// reset: 2000-01-01 00:00:00, both stages empty
// rsp.ready low holds the result; one more beat waits in the input stage, then req.ready drops
module calendar_clock_counter_unit (
	input logic       clk,
	input logic       arst_n,
	ccc_req_if.sink   req,
	ccc_rsp_if.source rsp
);
	logic                  in_fire;
	logic                  out_free;
	logic                  adv;

	// input stage
	logic                  valid_s1;
	ccc_pkg::ccc_load_t    load_s1;
	ccc_pkg::ccc_load_t    load_d;
	logic [15:0]           year_fix;
	logic [31:0]           recip_prod;

	// clock / calendar state
	ccc_pkg::ccc_state_t   state_q;
	ccc_pkg::ccc_state_t   state_nxt;

	// output register
	logic                  out_valid_q;
	ccc_pkg::ccc_result_t  out_q;
	ccc_pkg::ccc_result_t  res_d;

	// handshake: input stage moves on whenever the output register is free or being drained
	assign out_free  = !out_valid_q || rsp.ready;
	assign adv       = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign in_fire   = req.valid && req.ready;

	// first stage: fix month, year and time fields, and divide the year by 400
	// (drop four bits for the factor 16, then a reciprocal multiply for the factor 25;
	// the remainder is taken in the next stage)
	assign year_fix   = (req.set_year == '0) ? ccc_pkg::DEFAULT_YEAR : req.set_year;
	assign recip_prod = 32'(year_fix[15:4]) * 32'(ccc_pkg::YEAR_RECIP);

	always_comb begin
		load_d.req_type    = ccc_pkg::ccc_req_type_t'(req.req_type);
		load_d.month       = ((req.set_month == '0) || (req.set_month > ccc_pkg::MONTH_LAST)) ?
			4'd1 : req.set_month;
		load_d.day         = req.set_day;
		load_d.year        = year_fix;
		load_d.year_div400 = recip_prod[ccc_pkg::YEAR_RECIP_SHIFT +: 8];
		load_d.hour        = (req.set_hour < ccc_pkg::HOURS_DAY) ? req.set_hour : '0;
		load_d.minute      = (req.set_minute < ccc_pkg::UNITS_60) ? req.set_minute : '0;
		load_d.second      = (req.set_second < ccc_pkg::UNITS_60) ? req.set_second : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			load_s1 <= load_d;
		end
	end

	// second stage: tick or load against the current state
	ccc_advance u_advance (
		.cur  (state_q),
		.load (load_s1),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.year        <= ccc_pkg::DEFAULT_YEAR;
			state_q.month       <= 4'd1;
			state_q.day         <= 5'd1;
			state_q.hour        <= '0;
			state_q.minute      <= '0;
			state_q.second      <= '0;
			state_q.year_mod400 <= ccc_pkg::MOD_OF_DEFAULT;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result beat: 12-hour form shows midnight and noon as 12
	always_comb begin
		res_d.year   = state_nxt.year;
		res_d.month  = state_nxt.month;
		res_d.day    = state_nxt.day;
		res_d.hour   = state_nxt.hour;
		res_d.minute = state_nxt.minute;
		res_d.second = state_nxt.second;
		res_d.is_pm  = (state_nxt.hour >= ccc_pkg::HOUR_NOON);
		if (state_nxt.hour == '0) begin
			res_d.hour_twelve = 4'd12;
		end else if (state_nxt.hour > ccc_pkg::HOUR_NOON) begin
			res_d.hour_twelve = 4'(state_nxt.hour - ccc_pkg::HOUR_NOON);
		end else begin
			res_d.hour_twelve = 4'(state_nxt.hour);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cur_year    = out_q.year;
	assign rsp.cur_month   = out_q.month;
	assign rsp.cur_day     = out_q.day;
	assign rsp.cur_hour    = out_q.hour;
	assign rsp.cur_minute  = out_q.minute;
	assign rsp.cur_second  = out_q.second;
	assign rsp.hour_twelve = out_q.hour_twelve;
	assign rsp.is_pm       = out_q.is_pm;

	// a beat that leaves the input stage always lands in the output register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("input stage advanced without a result beat");

	// back-pressure only when both stages are full and the sink stalls
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready))
		else $error("req.ready dropped with room left");

	// a tick that does not wrap the seconds steps them and leaves minute and day alone
	a_tick_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (load_s1.req_type == ccc_pkg::REQ_TICK) && (state_q.second != ccc_pkg::SEC_LAST))
		|=> (state_q.second == 6'($past(state_q.second) + 6'd1))
			&& (state_q.minute == $past(state_q.minute))
			&& (state_q.day == $past(state_q.day)))
		else $error("tick without carry changed more than the seconds");

	// the day always lies within its month
	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.day != '0) && (state_q.day <= ccc_pkg::month_days(state_q.month,
			ccc_pkg::is_leap(state_q.year_mod400))))
		else $error("day outside month length");

endmodule

/* hw/rtl/ccc_advance.sv */
module ccc_advance (
	input  ccc_pkg::ccc_state_t cur,
	input  ccc_pkg::ccc_load_t  load,
	output ccc_pkg::ccc_state_t nxt
);
	logic              sec_wrap;
	logic              min_wrap;
	logic              hour_wrap;
	logic              day_wrap;
	logic              month_wrap;
	logic [4:0]        cur_mdays;
	ccc_pkg::ccc_state_t tick_st;
	logic [15:0]       span_base;
	logic [8:0]        ld_mod;
	logic [4:0]        ld_mdays;
	ccc_pkg::ccc_state_t load_st;

	// carry chain of a one-second tick
	assign cur_mdays  = ccc_pkg::month_days(cur.month, ccc_pkg::is_leap(cur.year_mod400));
	assign sec_wrap   = (cur.second == ccc_pkg::SEC_LAST);
	assign min_wrap   = sec_wrap && (cur.minute == ccc_pkg::MIN_LAST);
	assign hour_wrap  = min_wrap && (cur.hour == ccc_pkg::HOUR_LAST);
	assign day_wrap   = hour_wrap && (cur.day >= cur_mdays);
	assign month_wrap = day_wrap && (cur.month == ccc_pkg::MONTH_LAST);

	always_comb begin
		tick_st        = cur;
		tick_st.second = sec_wrap ? '0 : 6'(cur.second + 6'd1);
		if (sec_wrap) begin
			tick_st.minute = min_wrap ? '0 : 6'(cur.minute + 6'd1);
		end
		if (min_wrap) begin
			tick_st.hour = hour_wrap ? '0 : 5'(cur.hour + 5'd1);
		end
		if (hour_wrap) begin
			tick_st.day = day_wrap ? 5'd1 : 5'(cur.day + 5'd1);
		end
		if (day_wrap) begin
			tick_st.month = month_wrap ? 4'd1 : 4'(cur.month + 4'd1);
		end
		if (month_wrap) begin
			if (cur.year == ccc_pkg::LAST_YEAR) begin
				tick_st.year        = ccc_pkg::FIRST_YEAR;
				tick_st.year_mod400 = ccc_pkg::MOD_OF_FIRST;
			end else begin
				tick_st.year        = 16'(cur.year + 16'd1);
				tick_st.year_mod400 = (cur.year_mod400 == ccc_pkg::SPAN_LAST) ? '0 :
					9'(cur.year_mod400 + 9'd1);
			end
		end
	end

	// remainder from the quotient found in the first stage
	assign span_base = 16'(16'(load.year_div400) * ccc_pkg::YEAR_SPAN);
	assign ld_mod    = 9'(load.year - span_base);
	assign ld_mdays  = ccc_pkg::month_days(load.month, ccc_pkg::is_leap(ld_mod));

	always_comb begin
		load_st.year        = load.year;
		load_st.year_mod400 = ld_mod;
		load_st.month       = load.month;
		load_st.day         = ((load.day == '0) || (load.day > ld_mdays)) ? 5'd1 : load.day;
		load_st.hour        = load.hour;
		load_st.minute      = load.minute;
		load_st.second      = load.second;
	end

	assign nxt = (load.req_type == ccc_pkg::REQ_LOAD) ? load_st : tick_st;

endmodule
